@@ rtl/evacc_pkg.sv @@
// ----------------------------------------------------------------------------
// evacc_pkg
// Shared types, widths and constants of the accelerated encoder year selector.
// ----------------------------------------------------------------------------
package evacc_pkg;

    localparam int YEAR_W  = 18;
    localparam int COUNT_W = 32;
    localparam int MS_W    = 32;
    localparam int GAP_W   = 16;
    localparam int STEP_W  = 12;
    localparam int SUM_W   = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_GAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_FAST_GAP = 3'd4;

    // register reset values
    localparam logic signed [YEAR_W-1:0] VALUE_MIN_RST  = YEAR_W'(-100000);
    localparam logic signed [YEAR_W-1:0] VALUE_MAX_RST  = YEAR_W'(2100);
    localparam logic [GAP_W-1:0]         SAVE_DELAY_RST = GAP_W'(4 * 1000);
    localparam logic [GAP_W-1:0]         FAST_GAP_RST   = GAP_W'(50);
    localparam logic [GAP_W-1:0]         VFAST_GAP_RST  = GAP_W'(20);

    // acceleration bands of the year value
    localparam logic signed [YEAR_W-1:0] BAND_HI_YEAR = YEAR_W'(1900);
    localparam logic signed [YEAR_W-1:0] BAND_LO_YEAR = YEAR_W'(-99900);
    localparam logic signed [YEAR_W-1:0] MID_HI_YEAR  = YEAR_W'(-1000);
    localparam logic signed [YEAR_W-1:0] MID_LO_YEAR  = YEAR_W'(-99000);

    localparam int FAR_MULT   = 2;
    localparam int MID_MULT   = 20;
    localparam int NEAR_MULT  = 200;
    localparam int VFAST_MULT = 5;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        BAND_FAR,
        BAND_MID,
        BAND_NEAR
    } band_t;

    typedef struct packed {
        logic             command;
        logic             clk_level;
        logic             dt_level;
        logic [MS_W-1:0]  now_ms;
        logic [GAP_W-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic signed [YEAR_W-1:0] value_min;
        logic signed [YEAR_W-1:0] value_max;
        logic [GAP_W-1:0]         save_delay_ms;
        logic [GAP_W-1:0]         fast_gap_ms;
        logic [GAP_W-1:0]         very_fast_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       edge_count;
        logic [COUNT_W-1:0]       seen_count;
        logic [MS_W-1:0]          last_change_ms;
        logic signed [YEAR_W-1:0] year;
        logic [GAP_W-1:0]         save_countdown;
    } state_t;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year_value;
        logic                     changed;
        logic                     save_strobe;
    } result_t;

    // step magnitude for a band, a fast flag and a very-fast flag
    function automatic logic [STEP_W-2:0] step_mag(band_t band, logic fast, logic vfast);
        logic [STEP_W-2:0] mag;
        mag = (STEP_W-1)'(1);
        if (fast)
        begin
            unique case (band)
                BAND_FAR:  mag = vfast ? (STEP_W-1)'(FAR_MULT * VFAST_MULT)
                                       : (STEP_W-1)'(FAR_MULT);
                BAND_MID:  mag = vfast ? (STEP_W-1)'(MID_MULT * VFAST_MULT)
                                       : (STEP_W-1)'(MID_MULT);
                BAND_NEAR: mag = vfast ? (STEP_W-1)'(NEAR_MULT * VFAST_MULT)
                                       : (STEP_W-1)'(NEAR_MULT);
                default:   mag = (STEP_W-1)'(1);
            endcase
        end
        return mag;
    endfunction

endpackage

@@ rtl/evacc_calc.sv @@
// ----------------------------------------------------------------------------
// evacc_calc
// Next state and result for one item: edge counting, accelerated step,
// clamping and save countdown.
// ----------------------------------------------------------------------------
module evacc_calc (
    input  evacc_pkg::item_t   item,
    input  evacc_pkg::cfg_t    cfg,
    input  evacc_pkg::state_t  st,
    output evacc_pkg::state_t  st_next,
    output evacc_pkg::result_t res
);
    import evacc_pkg::*;

    logic                      moved;
    logic [COUNT_W-1:0]        diff;
    logic [MS_W-1:0]           gap;
    logic                      fast;
    logic                      vfast;
    band_t                     band;
    logic [STEP_W-2:0]         mag;
    logic signed [SUM_W-1:0]   step;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lim_min;
    logic signed [SUM_W-1:0]   lim_max;
    logic signed [YEAR_W-1:0]  clamped;
    logic                      changed;
    logic [GAP_W-1:0]          cnt_load;
    logic                      strobe;

    assign moved = st.edge_count != st.seen_count;
    assign diff  = st.edge_count - st.seen_count;
    assign gap   = item.now_ms - st.last_change_ms;
    assign fast  = gap < {{(MS_W-GAP_W){1'b0}}, cfg.fast_gap_ms};
    assign vfast = gap < {{(MS_W-GAP_W){1'b0}}, cfg.very_fast_gap_ms};

    always_comb
    begin
        priority if (st.year > BAND_HI_YEAR || st.year < BAND_LO_YEAR)
            band = BAND_FAR;
        else if (st.year > MID_HI_YEAR || st.year < MID_LO_YEAR)
            band = BAND_MID;
        else
            band = BAND_NEAR;
    end

    assign mag  = step_mag(band, fast, vfast);
    assign step = diff[COUNT_W-1] ? -$signed({{(SUM_W-STEP_W+1){1'b0}}, mag})
                                  :  $signed({{(SUM_W-STEP_W+1){1'b0}}, mag});
    assign sum     = SUM_W'(st.year) + step;
    assign lim_min = SUM_W'(cfg.value_min);
    assign lim_max = SUM_W'(cfg.value_max);

    always_comb
    begin
        priority if (sum < lim_min)
            clamped = cfg.value_min;
        else if (sum > lim_max)
            clamped = cfg.value_max;
        else
            clamped = sum[YEAR_W-1:0];
    end

    assign changed  = item.command == CMD_TICK && moved && clamped != st.year;
    assign cnt_load = changed ? cfg.save_delay_ms : st.save_countdown;

    always_comb
    begin
        st_next = st;
        strobe  = 1'b0;
        unique case (item.command)
            CMD_EDGE:
            begin
                if (item.clk_level != item.dt_level)
                    st_next.edge_count = st.edge_count - COUNT_W'(1);
                else
                    st_next.edge_count = st.edge_count + COUNT_W'(1);
            end
            CMD_TICK:
            begin
                if (moved)
                begin
                    st_next.seen_count     = st.edge_count;
                    st_next.last_change_ms = item.now_ms;
                    st_next.year           = clamped;
                end
                if (cnt_load != '0)
                begin
                    if (item.elapsed_ms >= cnt_load)
                    begin
                        st_next.save_countdown = '0;
                        strobe                 = 1'b1;
                    end
                    else
                        st_next.save_countdown = cnt_load - item.elapsed_ms;
                end
                else
                    st_next.save_countdown = cnt_load;
            end
            default: st_next = st;
        endcase
    end

    assign res.year_value  = st_next.year;
    assign res.changed     = changed;
    assign res.save_strobe = strobe;

endmodule

@@ rtl/encoder_value_with_acceleration.sv @@
// ----------------------------------------------------------------------------
// encoder_value_with_acceleration
// Rotary encoder year selector with speed-dependent step acceleration.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result. An item is taken into an input
// register; when the output register is free or being drained, its result is
// formed from that register and the block state in one pass and lands in the
// output register. One item can be taken each cycle as long as results are
// drained. Encoder edge items (tuser = 0) step the raw edge counter; update
// ticks (tuser = 1) turn movement into a year change, clamp it and run the
// save countdown. Registers take effect on the cycle after the write.
module encoder_value_with_acceleration (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [evacc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [evacc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // clk_level, dt_level, now_ms[31:0], elapsed_ms[15:0], zero fill
    input  logic [evacc_pkg::S_TDATA_W-1:0]       s_tdata,
    // command
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // year_value[17:0], changed, save_strobe, zero fill
    output logic [evacc_pkg::M_TDATA_W-1:0]       m_tdata
);
    import evacc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    m_valid_reg;
    logic    fire;
    item_t   in_item;

    assign in_item.command    = s_tuser;
    assign in_item.clk_level  = s_tdata[0];
    assign in_item.dt_level   = s_tdata[1];
    assign in_item.now_ms     = s_tdata[MS_W+1:2];
    assign in_item.elapsed_ms = s_tdata[MS_W+GAP_W+1:MS_W+2];

    // work the held item when the output register is free or being emptied
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_min        <= VALUE_MIN_RST;
            cfg_reg.value_max        <= VALUE_MAX_RST;
            cfg_reg.save_delay_ms    <= SAVE_DELAY_RST;
            cfg_reg.fast_gap_ms      <= FAST_GAP_RST;
            cfg_reg.very_fast_gap_ms <= VFAST_GAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VALUE_MIN:     cfg_reg.value_min        <= cfg_data;
                REG_VALUE_MAX:     cfg_reg.value_max        <= cfg_data;
                REG_SAVE_DELAY:    cfg_reg.save_delay_ms    <= cfg_data[GAP_W-1:0];
                REG_FAST_GAP:      cfg_reg.fast_gap_ms      <= cfg_data[GAP_W-1:0];
                REG_VERY_FAST_GAP: cfg_reg.very_fast_gap_ms <= cfg_data[GAP_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    evacc_calc u_calc (
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
            begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= in_item;
        if (fire)
            res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-YEAR_W-2){1'b0}}, res_reg.save_strobe,
                       res_reg.changed, res_reg.year_value};

`ifndef NO_ASSERTIONS
    // an edge item never reports a change or a save
    a_edge_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.command == CMD_EDGE |=> !res_reg.changed && !res_reg.save_strobe)
        else $error("edge item reported change or save");

    // a save strobe leaves the countdown idle
    a_strobe_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_next.save_strobe |=> state_reg.save_countdown == '0)
        else $error("countdown not cleared after save strobe");

    // a worked item always produces a pending result
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_valid_reg)
        else $error("worked item produced no result");

    // state only moves when an item is worked
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("state changed without an item");
`endif

endmodule
